FILE: rtl/ps2md_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse decoder package
// Shared types, byte codes and the axis helper used by the decoder modules.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] ATTACH_BYTE = 8'hAA;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;

  // Bit positions inside the packet header byte.
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_X_SIGN = 4;
  localparam int HDR_Y_SIGN = 5;
  localparam int HDR_X_OVF  = 6;
  localparam int HDR_Y_OVF  = 7;

  localparam logic [8:0] AXIS_MIN = 9'h100;  // -256
  localparam logic [8:0] AXIS_MAX = 9'h0FF;  //  255

  typedef enum logic {
    EVT_MOTION = 1'b0,
    EVT_ATTACH = 1'b1
  } ps2md_event_t;

  typedef struct packed {
    ps2md_event_t      event_kind;
    logic              button_left;
    logic              button_right;
    logic              button_middle;
    logic signed [8:0] move_x;
    logic signed [9:0] move_y;
    logic signed [7:0] move_z;
  } ps2md_result_t;

  // Nine-bit axis delta: sign bit on top of the data byte, or a saturated
  // extreme when the overflow flag is set.
  function automatic logic [8:0] axis_delta(input logic [7:0] data, input logic ovf,
                                            input logic sign);
    logic [8:0] val;
    if (ovf) begin
      val = sign ? AXIS_MIN : AXIS_MAX;
    end else begin
      val = {sign, data};
    end
    return val;
  endfunction

endpackage

FILE: rtl/ps2md_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse decoder core
// Byte position counter, packet byte store, wheel register and packet decode.
// ----------------------------------------------------------------------------
module ps2md_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic                    byte_valid,
  input  logic [7:0]              byte_in,
  output logic                    res_valid,
  output ps2md_pkg::ps2md_result_t res
);
  import ps2md_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] bytes_r [0:2];
  logic       wheel_r, wheel_nxt;

  logic       start_ok, is_ack, is_attach, done, take;
  logic [7:0] head, data_x, data_y;
  logic [8:0] dx, dy_raw;

  always_comb begin
    start_ok  = (pos_r != 2'd0) || byte_in[HDR_SYNC];
    is_ack    = (pos_r == 2'd0) && (byte_in == ACK_BYTE);
    is_attach = (pos_r == 2'd1) && (bytes_r[0] == ATTACH_BYTE) && (byte_in == ZERO_BYTE);
    done      = ((pos_r == 2'd2) && !wheel_r) || (pos_r == 2'd3);
    take      = byte_valid && start_ok;

    head   = bytes_r[0];
    data_x = bytes_r[1];
    data_y = (pos_r == 2'd2) ? byte_in : bytes_r[2];
    dx     = axis_delta(data_x, head[HDR_X_OVF], head[HDR_X_SIGN]);
    dy_raw = axis_delta(data_y, head[HDR_Y_OVF], head[HDR_Y_SIGN]);

    res_valid = take && (is_attach || done);
    res       = '0;
    if (is_attach) begin
      res.event_kind = EVT_ATTACH;
    end else begin
      res.event_kind    = EVT_MOTION;
      res.button_left   = head[HDR_LEFT];
      res.button_right  = head[HDR_RIGHT];
      res.button_middle = head[HDR_MIDDLE];
      res.move_x        = dx;
      res.move_y        = 10'(-{dy_raw[8], dy_raw});
      res.move_z        = (wheel_r && (pos_r == 2'd3)) ? byte_in : ZERO_BYTE;
    end

    pos_nxt = pos_r;
    if (take) begin
      if (is_ack || is_attach || done) begin
        pos_nxt = 2'd0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end

    wheel_nxt = wheel_r;
    if (cfg_we) begin
      wheel_nxt = cfg_wdata;
    end else if (take && is_attach) begin
      wheel_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      wheel_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      wheel_r <= wheel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (pos_r != 2'd3)) begin
      bytes_r[pos_r] <= byte_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_restart_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == 2'd0))
    else $error("byte position did not restart after a result");

  a_attach_clears_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.event_kind == EVT_ATTACH) && !cfg_we) |=> !wheel_r)
    else $error("attach did not clear the wheel register");

  a_attach_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.event_kind == EVT_ATTACH)) |->
      (!res.button_left && !res.button_right && !res.button_middle &&
       (res.move_x == '0) && (res.move_y == '0) && (res.move_z == '0)))
    else $error("attach result carries nonzero motion fields");

  a_unsynced_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && (pos_r == 2'd0) && !byte_in[HDR_SYNC]) |=> (pos_r == 2'd0))
    else $error("header byte without sync bit was not dropped");
`endif

endmodule

FILE: rtl/ps2md_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse decoder result register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ps2md_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  ps2md_pkg::ps2md_result_t load_data,
  output logic                    slot_free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ps2md_pkg::ps2md_result_t out_data
);
  import ps2md_pkg::*;

  logic          valid_r, valid_nxt;
  ps2md_result_t data_r;

  always_comb begin
    slot_free = !valid_r || out_ready;
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/ps2_mouse_packet_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder, top level
// Assembles mouse bytes into motion packets and reports device attach words.
// ----------------------------------------------------------------------------
// The byte that completes a packet is first accepted into the input register,
// then decoded out of it into the result register once that register can take
// a word; the result word is presented from the result register.
// Throughput: one byte per cycle; input is held off only while the result
// register is full and the sink is stalled.
// Reset (rst_n, synchronous, active low) empties both registers, zeroes the
// byte position and clears the wheel register.
module ps2_mouse_packet_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: wheel_enable.
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Input byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] button_left, [1] button_right,
                                  // [2] button_middle, [11:3] move_x,
                                  // [21:12] move_y, [29:22] move_z, [31:30] zero
  output logic        out_tuser   // [0] event_kind
);
  import ps2md_pkg::*;

  // Input register. A byte held here is decoded in the cycle the result
  // register can take an outcome, whether or not the byte yields a result.
  logic          in_valid_r, in_valid_nxt;
  logic [7:0]    in_byte_r;
  logic          advance;
  logic          slot_free;
  logic          res_valid;
  ps2md_result_t res;
  ps2md_result_t out_res;

  assign advance   = in_valid_r && slot_free;
  assign in_tready = !in_valid_r || slot_free;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Packet state and decode.
  ps2md_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (advance),
    .byte_in    (in_byte_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register; it frees its slot in the same cycle the sink takes a word.
  ps2md_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .load_data (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign out_tdata = {2'b00, out_res.move_z, out_res.move_y, out_res.move_x,
                      out_res.button_middle, out_res.button_right, out_res.button_left};
  assign out_tuser = out_res.event_kind;

endmodule
